### rtl/mufc_pkg.sv
`default_nettype none
package mufc_pkg;

    // Frame constants
    localparam logic [7:0] HEADER_BYTE    = 8'hA5;
    localparam logic [7:0] ONE_BYTE_LIMIT = 8'hFF;
    localparam int         FRAME_BYTES    = 5;
    localparam int         LEN_W          = $clog2(FRAME_BYTES + 1);
    localparam int         IDX_W          = $clog2(FRAME_BYTES);

    // Input item function
    typedef enum logic {
        FUNC_CMD = 1'b0,
        FUNC_RX  = 1'b1
    } t_func;

    // Result kind
    typedef enum logic {
        KIND_TX   = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    // Read result status
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CSUM = 2'd1,
        STATUS_OVF  = 2'd2
    } t_status;

    // Command frame handed from the builder to the top level
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]            len;
        logic                        bare_read;
    } t_frame;

endpackage
`default_nettype wire

### rtl/mufc_in_if.sv
`default_nettype none
interface mufc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  reg_addr;
    logic [15:0] wr_data;
    logic [7:0]  rx_byte;
    logic        rx_last;

    modport source (
        output valid, func, reg_addr, wr_data, rx_byte, rx_last,
        input  ready
    );
    modport sink (
        input  valid, func, reg_addr, wr_data, rx_byte, rx_last,
        output ready
    );
endinterface
`default_nettype wire

### rtl/mufc_out_if.sv
`default_nettype none
interface mufc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, kind, tx_byte, read_value, status, last,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_byte, read_value, status, last,
        output ready
    );
endinterface
`default_nettype wire

### rtl/mufc_tx_frame.sv
`default_nettype none
module mufc_tx_frame
    import mufc_pkg::*;
(
    input  wire logic [7:0]  i_reg_addr,
    input  wire logic [15:0] i_wr_data,
    output t_frame           o_frame
);

    logic [7:0] base_sum;
    logic [7:0] one_sum;
    logic [7:0] two_sum;

    // Running checksum over header, address and data bytes
    assign base_sum = HEADER_BYTE + i_reg_addr;
    assign one_sum  = base_sum + i_wr_data[7:0];
    assign two_sum  = base_sum + i_wr_data[15:8] + i_wr_data[7:0];

    // Lay out the frame bytes and its length
    always_comb begin
        o_frame           = '0;
        o_frame.bytes[0]  = HEADER_BYTE;
        o_frame.bytes[1]  = i_reg_addr;
        if (i_wr_data == 16'd0) begin
            o_frame.len       = LEN_W'(2);
            o_frame.bare_read = 1'b1;
        end else if (i_wr_data < {8'd0, ONE_BYTE_LIMIT}) begin
            o_frame.bytes[2] = i_wr_data[7:0];
            o_frame.bytes[3] = ~one_sum;
            o_frame.len      = LEN_W'(4);
        end else begin
            o_frame.bytes[2] = i_wr_data[15:8];
            o_frame.bytes[3] = i_wr_data[7:0];
            o_frame.bytes[4] = ~two_sum;
            o_frame.len      = LEN_W'(5);
        end
    end

endmodule
`default_nettype wire

### rtl/meter_uart_frame_codec_top.sv
`default_nettype none
// Host-side UART framing codec for a metering chip link. A command item
// (func 0) yields two to five transmit beats: header 0xA5, the address and,
// for nonzero data, one or two data bytes and the inverted additive checksum;
// zero data is a bare read request that latches the address and clears the
// response accumulators. For a response item (func 1), data bytes are
// shifted into the value and give no beat, and the byte marked last gives
// one read-result beat with status ok, checksum error or overflow. Result
// beats leave from a frame register one per cycle while o_rsp.ready is
// high; the next item is taken in the same cycle that the last beat of the
// previous one is taken, and output back-pressure stalls the input side.
module meter_uart_frame_codec_top
    import mufc_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mufc_in_if.sink     i_cmd,
    mufc_out_if.source  o_rsp
);

    localparam int CNT_W = $clog2(MAX_DATA_BYTES + 2);

    // Response state
    logic [7:0]       r_read_addr, n_read_addr;
    logic [31:0]      r_value_acc, n_value_acc;
    logic [7:0]       r_sum_acc,   n_sum_acc;
    logic [CNT_W-1:0] r_byte_cnt,  n_byte_cnt;

    // Frame register feeding the output
    logic                        r_busy,   n_busy;
    logic [FRAME_BYTES-1:0][7:0] r_bytes,  n_bytes;
    logic [LEN_W-1:0]            r_len,    n_len;
    logic [IDX_W-1:0]            r_idx,    n_idx;
    t_kind                       r_kind,   n_kind;
    logic [31:0]                 r_value,  n_value;
    t_status                     r_status, n_status;

    t_frame     tx_frame;
    logic       out_last;
    logic       out_take;
    logic       in_accept;
    logic [7:0] expect_sum;

    mufc_tx_frame u_tx_frame (
        .i_reg_addr (i_cmd.reg_addr),
        .i_wr_data  (i_cmd.wr_data),
        .o_frame    (tx_frame)
    );

    // Handshakes
    assign out_last  = (r_kind == KIND_READ) ||
                       (LEN_W'(r_idx) == r_len - LEN_W'(1));
    assign out_take  = o_rsp.valid && o_rsp.ready;
    assign i_cmd.ready = !r_busy || (out_take && out_last);
    assign in_accept = i_cmd.valid && i_cmd.ready;

    assign expect_sum = ~(HEADER_BYTE + r_read_addr + r_sum_acc);

    // Output beat from the frame register
    assign o_rsp.valid      = r_busy;
    assign o_rsp.kind       = r_kind;
    assign o_rsp.tx_byte    = (r_kind == KIND_TX) ? r_bytes[r_idx] : 8'd0;
    assign o_rsp.read_value = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.last       = out_last;

    // Next state: advance the frame, load a new item, accumulate response bytes
    always_comb begin
        n_read_addr = r_read_addr;
        n_value_acc = r_value_acc;
        n_sum_acc   = r_sum_acc;
        n_byte_cnt  = r_byte_cnt;
        n_busy      = r_busy;
        n_bytes     = r_bytes;
        n_len       = r_len;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_value     = r_value;
        n_status    = r_status;

        if (out_take) begin
            if (out_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end

        if (in_accept) begin
            if (i_cmd.func == FUNC_CMD) begin
                n_busy   = 1'b1;
                n_bytes  = tx_frame.bytes;
                n_len    = tx_frame.len;
                n_idx    = '0;
                n_kind   = KIND_TX;
                n_value  = '0;
                n_status = STATUS_OK;
                if (tx_frame.bare_read) begin
                    n_read_addr = i_cmd.reg_addr;
                    n_value_acc = '0;
                    n_sum_acc   = '0;
                    n_byte_cnt  = '0;
                end
            end else if (!i_cmd.rx_last) begin
                if (r_byte_cnt < CNT_W'(MAX_DATA_BYTES)) begin
                    n_value_acc = {r_value_acc[23:0], i_cmd.rx_byte};
                    n_sum_acc   = r_sum_acc + i_cmd.rx_byte;
                    n_byte_cnt  = r_byte_cnt + CNT_W'(1);
                end else begin
                    n_byte_cnt  = CNT_W'(MAX_DATA_BYTES + 1);
                end
            end else begin
                n_busy  = 1'b1;
                n_bytes = '0;
                n_len   = LEN_W'(1);
                n_idx   = '0;
                n_kind  = KIND_READ;
                if (r_byte_cnt > CNT_W'(MAX_DATA_BYTES)) begin
                    n_value  = '0;
                    n_status = STATUS_OVF;
                end else begin
                    n_value  = r_value_acc;
                    n_status = (expect_sum == i_cmd.rx_byte) ? STATUS_OK : STATUS_CSUM;
                end
                n_value_acc = '0;
                n_sum_acc   = '0;
                n_byte_cnt  = '0;
            end
        end
    end

    // Control and response state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_read_addr <= '0;
            r_value_acc <= '0;
            r_sum_acc   <= '0;
            r_byte_cnt  <= '0;
            r_idx       <= '0;
            r_kind      <= KIND_TX;
            r_len       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_read_addr <= n_read_addr;
            r_value_acc <= n_value_acc;
            r_sum_acc   <= n_sum_acc;
            r_byte_cnt  <= n_byte_cnt;
            r_idx       <= n_idx;
            r_kind      <= n_kind;
            r_len       <= n_len;
        end
    end

    // Frame payload
    always_ff @(posedge i_clk) begin
        r_bytes  <= n_bytes;
        r_value  <= n_value;
        r_status <= n_status;
    end

    // Checks
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (LEN_W'(r_idx) < r_len))
        else $error("frame index beyond frame length");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == KIND_READ && o_rsp.status == STATUS_OVF)
        |-> (o_rsp.read_value == 32'd0))
        else $error("overflow result carries a value");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= CNT_W'(MAX_DATA_BYTES + 1))
        else $error("byte count past saturation");

    a_read_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd.func == FUNC_CMD && i_cmd.wr_data == 16'd0)
        |=> (r_read_addr == $past(i_cmd.reg_addr) && r_byte_cnt == '0))
        else $error("read request did not latch address");

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
module tb;
    import mufc_pkg::*;

    localparam int DATA_BYTES_MAX  = 4;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        t_func       func;
        logic [7:0]  reg_addr;
        logic [15:0] wr_data;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } t_link_item;

    typedef struct {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [31:0] read_value;
        t_status     status;
        logic        last;
    } t_link_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mufc_in_if  cmd_if ();
    mufc_out_if rsp_if ();

    meter_uart_frame_codec_top #(
        .MAX_DATA_BYTES(DATA_BYTES_MAX)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Items waiting to be driven, beats waiting to be seen
    t_link_item cmd_backlog[$];
    t_link_beat awaited_beats[$];
    int         queued_items = 0;
    int         fault_cnt    = 0;
    int         send_gap_pct = 0;
    int         take_gap_pct = 0;

    // Mirror of the link state
    logic [7:0]  latched_addr = 8'h00;
    logic [31:0] value_acc    = 32'h0;
    logic [7:0]  data_sum     = 8'h00;
    logic [2:0]  data_cnt     = 3'd0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic string beat_text(input logic kind, input logic [7:0] tx,
                                        input logic [31:0] val, input logic [1:0] st,
                                        input logic last);
        return $sformatf("kind=%0d tx=%02h value=%08h status=%0d last=%0d",
                         kind, tx, val, st, last);
    endfunction

    task automatic clear_reply_acc();
        value_acc = 32'h0;
        data_sum  = 8'h00;
        data_cnt  = 3'd0;
    endtask

    // Work out the beats that one accepted item gives rise to
    task automatic predict_link_beats(input t_link_item it);
        logic [7:0] frame[$];
        logic [7:0] csum;
        t_link_beat b;
        if (it.func == FUNC_CMD) begin
            frame = {HEADER_BYTE, it.reg_addr};
            if (it.wr_data != 16'h0000) begin
                if (it.wr_data < {8'h00, ONE_BYTE_LIMIT}) begin
                    frame.push_back(it.wr_data[7:0]);
                end else begin
                    frame.push_back(it.wr_data[15:8]);
                    frame.push_back(it.wr_data[7:0]);
                end
                csum = 8'h00;
                foreach (frame[i]) csum += frame[i];
                frame.push_back(~csum);
            end else begin
                // bare read request: latch the address, start a clean reply
                latched_addr = it.reg_addr;
                clear_reply_acc();
            end
            foreach (frame[i]) begin
                b.kind       = KIND_TX;
                b.tx_byte    = frame[i];
                b.read_value = 32'h0;
                b.status     = STATUS_OK;
                b.last       = (i == frame.size() - 1);
                awaited_beats.push_back(b);
            end
        end else if (!it.rx_last) begin
            // data byte: shift in, or saturate the count past the limit
            if (data_cnt < DATA_BYTES_MAX) begin
                value_acc = {value_acc[23:0], it.rx_byte};
                data_sum  = data_sum + it.rx_byte;
                data_cnt  = data_cnt + 3'd1;
            end else begin
                data_cnt = 3'(DATA_BYTES_MAX + 1);
            end
        end else begin
            // checksum byte closes the reply
            csum         = HEADER_BYTE + latched_addr + data_sum;
            b.kind       = KIND_READ;
            b.tx_byte    = 8'h00;
            b.last       = 1'b1;
            if (data_cnt > DATA_BYTES_MAX) begin
                b.read_value = 32'h0;
                b.status     = STATUS_OVF;
            end else begin
                b.read_value = value_acc;
                b.status     = (it.rx_byte == ~csum) ? STATUS_OK : STATUS_CSUM;
            end
            awaited_beats.push_back(b);
            clear_reply_acc();
        end
    endtask

    task automatic queue_cmd(input logic [7:0] addr, input logic [15:0] data);
        t_link_item it;
        it.func     = FUNC_CMD;
        it.reg_addr = addr;
        it.wr_data  = data;
        it.rx_byte  = 8'($urandom);
        it.rx_last  = 1'($urandom_range(1));
        cmd_backlog.push_back(it);
        queued_items++;
    endtask

    task automatic queue_rx(input logic [7:0] rx, input logic last);
        t_link_item it;
        it.func     = FUNC_RX;
        it.reg_addr = 8'($urandom);
        it.wr_data  = 16'($urandom);
        it.rx_byte  = rx;
        it.rx_last  = last;
        cmd_backlog.push_back(it);
        queued_items++;
    endtask

    // Queue the data bytes of a reply and its checksum, spoilt on request
    task automatic queue_reply(input logic [7:0] addr, input logic [7:0] data[$],
                               input bit corrupt);
        logic [7:0] sum;
        logic [7:0] flip;
        sum  = HEADER_BYTE + addr;
        flip = 8'h01 << $urandom_range(7);
        foreach (data[i]) begin
            sum += data[i];
            queue_rx(data[i], 1'b0);
        end
        queue_rx(corrupt ? (~sum ^ flip) : ~sum, 1'b1);
    endtask

    function automatic logic [15:0] pick_write_data();
        case ($urandom_range(3))
            0: begin
                return 16'($urandom_range(16'h00FE, 1));
            end
            1: begin
                return {8'h00, ONE_BYTE_LIMIT};
            end
            2: begin
                return 16'($urandom_range(16'hFFFF, 16'h0100));
            end
            default: begin
                return 16'($urandom_range(16'hFFFF, 1));
            end
        endcase
    endfunction

    task automatic queue_directed();
        logic [7:0] data[$];
        // checksum-only replies with no read pending, good then bad
        queue_rx(8'h5A, 1'b1);
        queue_rx(8'h00, 1'b1);
        // read at the lowest address, writes across the data range
        queue_cmd(8'h00, 16'h0000);
        queue_cmd(8'hFF, 16'h0001);
        queue_cmd(8'h80, 16'h00FE);
        queue_cmd(8'h81, 16'h00FF);
        queue_cmd(8'h7F, 16'hFFFF);
        queue_cmd(8'h00, 16'h0100);
        // reply of a checksum byte only
        data = {};
        queue_reply(8'h00, data, 1'b0);
        // full reply with a write slipped in before it
        queue_cmd(8'hFF, 16'h0000);
        queue_cmd(8'h85, 16'h1234);
        data = {8'hFF, 8'h00, 8'h80, 8'h01};
        queue_reply(8'hFF, data, 1'b0);
        // bad checksum still reports the value
        queue_cmd(8'h3C, 16'h0000);
        data = {8'h12, 8'h34};
        queue_reply(8'h3C, data, 1'b1);
        // one data byte too many
        queue_cmd(8'h3D, 16'h0000);
        data = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        queue_reply(8'h3D, data, 1'b0);
    endtask

    // Mostly well-formed read exchanges and writes, some stray reply bytes
    task automatic queue_random(input int quota);
        int         start_cnt;
        int         pick;
        int         n;
        logic [7:0] addr;
        logic [7:0] data[$];
        start_cnt = queued_items;
        while (queued_items - start_cnt < quota) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                addr = 8'($urandom);
                n    = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(6, 5);
                data = {};
                repeat (n) data.push_back(8'($urandom));
                queue_cmd(addr, 16'h0000);
                if ($urandom_range(4) == 0) queue_cmd(8'($urandom), pick_write_data());
                queue_reply(addr, data, $urandom_range(4) == 0);
            end else if (pick < 85) begin
                queue_cmd(8'($urandom), pick_write_data());
            end else begin
                queue_rx(8'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    // Drive the next item once the current item has been taken
    always @(posedge i_clk) begin : drive_cmd
        t_link_item nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = cmd_backlog.pop_front();
                cmd_if.valid    <= 1'b1;
                cmd_if.func     <= nxt.func;
                cmd_if.reg_addr <= nxt.reg_addr;
                cmd_if.wr_data  <= nxt.wr_data;
                cmd_if.rx_byte  <= nxt.rx_byte;
                cmd_if.rx_last  <= nxt.rx_last;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // Predict on each accepted item, check each accepted beat
    always @(posedge i_clk) begin : watch_link
        t_link_item seen;
        t_link_beat want;
        string      got_txt;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                seen.func     = t_func'(cmd_if.func);
                seen.reg_addr = cmd_if.reg_addr;
                seen.wr_data  = cmd_if.wr_data;
                seen.rx_byte  = cmd_if.rx_byte;
                seen.rx_last  = cmd_if.rx_last;
                predict_link_beats(seen);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got_txt = beat_text(rsp_if.kind, rsp_if.tx_byte, rsp_if.read_value,
                                    rsp_if.status, rsp_if.last);
                if (awaited_beats.size() == 0) begin
                    if (fault_cnt < REPORT_LIMIT)
                        $display("%0t: beat with none awaited: %s", $realtime, got_txt);
                    fault_cnt++;
                end else begin
                    want = awaited_beats.pop_front();
                    if (rsp_if.kind !== want.kind || rsp_if.tx_byte !== want.tx_byte ||
                        rsp_if.read_value !== want.read_value ||
                        rsp_if.status !== want.status || rsp_if.last !== want.last) begin
                        if (fault_cnt < REPORT_LIMIT)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                     beat_text(want.kind, want.tx_byte, want.read_value,
                                               want.status, want.last),
                                     got_txt);
                        fault_cnt++;
                    end
                end
            end
        end
    end

    initial begin : run_link
        int phase;
        cmd_if.valid    = 1'b0;
        cmd_if.func     = FUNC_CMD;
        cmd_if.reg_addr = 8'h00;
        cmd_if.wr_data  = 16'h0000;
        cmd_if.rx_byte  = 8'h00;
        cmd_if.rx_last  = 1'b0;
        rsp_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin
                    send_gap_pct = 7;
                    take_gap_pct = 56;
                end
                1: begin
                    send_gap_pct = 56;
                    take_gap_pct = 7;
                end
                default: begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
            endcase
            if (phase == 0) queue_directed();
            queue_random(ITEMS_PER_PHASE);
            // hold the sender until the link has drained
            while (cmd_backlog.size() != 0 || cmd_if.valid || awaited_beats.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        if (awaited_beats.size() != 0) begin
            $display("%0d beats never arrived", awaited_beats.size());
            fault_cnt++;
        end
        if (fault_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Give up on a hung link
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/mufc_pkg.sv
rtl/mufc_in_if.sv
rtl/mufc_out_if.sv
rtl/mufc_tx_frame.sv
rtl/meter_uart_frame_codec_top.sv
test/tb.sv
